>>> hw/rtl/emt_pkg.sv
package emt_pkg;

  localparam int unsigned MaxExtentsDefault = 16;
  localparam int unsigned ResultLimit       = 16;
  localparam int unsigned CountW            = 5;
  localparam int unsigned LenW              = 15;
  localparam logic [15:0] LenMax            = 16'h7FFF;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TRIM   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DO,
    S_LOOK,
    S_TCNT,
    S_TRUN,
    S_NULL
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INS_SCAN,
    OP_INS_DO,
    OP_LOOK,
    OP_TRIM_CNT,
    OP_TRIM_RUN,
    OP_NULL
  } op_t;

  typedef struct packed {
    logic scan_done;
    logic look_done;
    logic cnt_done;
    logic run_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/emt_ctrl.sv
module emt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  input  emt_pkg::dp_status_t   dp_st,
  output logic                  in_ready,
  output emt_pkg::op_t          op
);

  emt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      emt_pkg::S_IDLE: begin
        if (in_valid) begin
          case (emt_pkg::cmd_t'(in_cmd))
            emt_pkg::CMD_INSERT: state_next = emt_pkg::S_SCAN;
            emt_pkg::CMD_LOOKUP: state_next = emt_pkg::S_LOOK;
            emt_pkg::CMD_TRIM:   state_next = emt_pkg::S_TCNT;
            default:             state_next = emt_pkg::S_NULL;
          endcase
        end
      end
      emt_pkg::S_SCAN: if (dp_st.scan_done) state_next = emt_pkg::S_DO;
      emt_pkg::S_DO:   if (dp_st.out_free) state_next = emt_pkg::S_IDLE;
      emt_pkg::S_LOOK: if (dp_st.out_free && dp_st.look_done) state_next = emt_pkg::S_IDLE;
      emt_pkg::S_TCNT: if (dp_st.cnt_done) state_next = emt_pkg::S_TRUN;
      emt_pkg::S_TRUN: if (dp_st.out_free && dp_st.run_done) state_next = emt_pkg::S_IDLE;
      emt_pkg::S_NULL: if (dp_st.out_free) state_next = emt_pkg::S_IDLE;
      default:         state_next = emt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = emt_pkg::OP_NOP;
    case (state)
      emt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = emt_pkg::OP_LOAD;
      end
      emt_pkg::S_SCAN: op = emt_pkg::OP_INS_SCAN;
      emt_pkg::S_DO:   if (dp_st.out_free) op = emt_pkg::OP_INS_DO;
      emt_pkg::S_LOOK: if (dp_st.out_free) op = emt_pkg::OP_LOOK;
      emt_pkg::S_TCNT: op = emt_pkg::OP_TRIM_CNT;
      emt_pkg::S_TRUN: if (dp_st.out_free) op = emt_pkg::OP_TRIM_RUN;
      emt_pkg::S_NULL: if (dp_st.out_free) op = emt_pkg::OP_NULL;
      default:         op = emt_pkg::OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/emt_dpath.sv
module emt_dpath #(
  parameter int unsigned MAX_EXTENTS = emt_pkg::MaxExtentsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  emt_pkg::op_t        op,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  logic [111:0]        in_data,
  input  logic                out_ready,
  output emt_pkg::dp_status_t dp_st,
  output logic                out_valid,
  output logic [55:0]         out_data,
  output logic                out_last
);

  localparam int unsigned Depth = (MAX_EXTENTS < emt_pkg::ResultLimit) ?
                                  MAX_EXTENTS : emt_pkg::ResultLimit;
  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned CW = emt_pkg::CountW;
  localparam int unsigned LW = emt_pkg::LenW;

  logic [31:0]   t_ls  [Depth];
  logic [31:0]   t_ps  [Depth];
  logic [LW-1:0] t_len [Depth];
  logic [CW-1:0] count;
  logic [4:0]    capacity;

  logic [31:0]   lb, pb, keep;
  logic [LW-1:0] len;
  logic [CW-1:0] idx, kc;
  logic          any_freed;

  logic [31:0]   l_ls, l_ps, r_ls, r_ps;
  logic [LW-1:0] l_len, r_len;
  logic          have_l, have_r;

  logic [1:0]    o_status;
  logic          o_found;
  logic [31:0]   o_mapped;
  logic [LW-1:0] o_freed;
  logic [CW-1:0] o_count;

  logic [IW-1:0] ri;
  logic          in_tab;
  logic [31:0]   c_ls, c_ps;
  logic [LW-1:0] c_len;
  logic [CW-1:0] eff_cap;

  assign ri     = idx[IW-1:0];
  assign in_tab = (idx < count);
  assign c_ls   = t_ls[ri];
  assign c_ps   = t_ps[ri];
  assign c_len  = t_len[ri];
  assign eff_cap = (capacity > CW'(Depth)) ? CW'(Depth) : capacity;

  // insert decision
  logic [32:0] l_end, l_pend, n_end, n_pend;
  logic [15:0] l_sum, r_sum;
  logic [16:0] b_sum;
  logic        ov_l, ov_r, l_ok, r_adj, both, r_ok;

  assign l_end  = {1'b0, l_ls} + 33'(l_len);
  assign l_pend = {1'b0, l_ps} + 33'(l_len);
  assign n_end  = {1'b0, lb} + 33'(len);
  assign n_pend = {1'b0, pb} + 33'(len);
  assign l_sum  = 16'(l_len) + 16'(len);
  assign r_sum  = 16'(r_len) + 16'(len);
  assign b_sum  = 17'(l_sum) + 17'(r_len);
  assign ov_l   = have_l && (l_end > {1'b0, lb});
  assign l_ok   = have_l && (l_end == {1'b0, lb}) && (l_pend == {1'b0, pb}) &&
                  (l_sum <= emt_pkg::LenMax);
  assign r_adj  = have_r && (n_end == {1'b0, r_ls}) && (n_pend == {1'b0, r_ps});
  assign both   = l_ok && r_adj && (b_sum <= 17'(emt_pkg::LenMax));
  assign ov_r   = have_r && (n_end > {1'b0, r_ls});
  assign r_ok   = r_adj && (r_sum <= emt_pkg::LenMax);

  // lookup and trim per entry
  logic [32:0]   c_end;
  logic          hit;
  logic [LW-1:0] keep_len;
  logic          freed;

  assign c_end = {1'b0, c_ls} + 33'(c_len);
  assign hit   = in_tab && (lb >= c_ls) && ({1'b0, lb} < c_end);

  always_comb begin
    if (c_ls >= keep) begin
      keep_len = '0;
    end else if (c_end > {1'b0, keep}) begin
      keep_len = LW'(keep - c_ls);
    end else begin
      keep_len = c_len;
    end
  end
  assign freed = (keep_len != c_len);

  // table write controls
  logic          shift_ins, shift_del, len_we, ent_we;
  logic [CW-1:0] w_pos, len_pos;
  logic [LW-1:0] len_val;
  logic [1:0]    ins_status;
  logic [CW-1:0] ins_count;

  always_comb begin
    shift_ins  = 1'b0;
    shift_del  = 1'b0;
    len_we     = 1'b0;
    ent_we     = 1'b0;
    w_pos      = idx;
    len_pos    = idx;
    len_val    = keep_len;
    ins_status = emt_pkg::ST_OK;
    ins_count  = count;
    if (op == emt_pkg::OP_INS_DO) begin
      if (len == '0) begin
        ins_status = emt_pkg::ST_BAD_LEN;
      end else if (ov_l) begin
        ins_status = emt_pkg::ST_OVERLAP;
      end else if (l_ok) begin
        len_we  = 1'b1;
        len_pos = idx - CW'(1);
        if (both) begin
          len_val   = b_sum[LW-1:0];
          shift_del = 1'b1;
          ins_count = count - CW'(1);
        end else begin
          len_val = l_sum[LW-1:0];
        end
      end else if (ov_r) begin
        ins_status = emt_pkg::ST_OVERLAP;
      end else if (r_ok) begin
        ent_we  = 1'b1;
        len_val = r_sum[LW-1:0];
      end else if (count >= eff_cap) begin
        ins_status = emt_pkg::ST_FULL;
      end else begin
        shift_ins = 1'b1;
        ins_count = count + CW'(1);
      end
    end else if (op == emt_pkg::OP_TRIM_RUN) begin
      len_we = in_tab && freed && (keep_len != '0);
    end
  end

  for (genvar j = 0; j < Depth; j++) begin : g_ent
    always_ff @(posedge clk) begin
      if (shift_ins && (CW'(j) > w_pos)) begin
        if (j > 0) begin
          t_ls[j]  <= t_ls[(j > 0) ? j - 1 : 0];
          t_ps[j]  <= t_ps[(j > 0) ? j - 1 : 0];
          t_len[j] <= t_len[(j > 0) ? j - 1 : 0];
        end
      end
      if ((shift_ins || ent_we) && (CW'(j) == w_pos)) begin
        t_ls[j]  <= lb;
        t_ps[j]  <= pb;
        t_len[j] <= shift_ins ? len : len_val;
      end
      if (shift_del && (CW'(j) >= w_pos) && (j + 1 < Depth)) begin
        t_ls[j]  <= t_ls[(j + 1 < Depth) ? j + 1 : j];
        t_ps[j]  <= t_ps[(j + 1 < Depth) ? j + 1 : j];
        t_len[j] <= t_len[(j + 1 < Depth) ? j + 1 : j];
      end
      if (len_we && (CW'(j) == len_pos)) begin
        t_len[j] <= len_val;
      end
    end
  end

  assign dp_st.scan_done = !(in_tab && (c_ls < lb));
  assign dp_st.look_done = !in_tab || hit;
  assign dp_st.cnt_done  = !in_tab;
  assign dp_st.run_done  = !in_tab;
  assign dp_st.out_free  = !out_valid || out_ready;

  logic emit;
  assign emit = (op == emt_pkg::OP_INS_DO) || (op == emt_pkg::OP_NULL) ||
                ((op == emt_pkg::OP_LOOK) && dp_st.look_done) ||
                ((op == emt_pkg::OP_TRIM_RUN) && (in_tab ? freed : !any_freed));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= 5'd4;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (op == emt_pkg::OP_INS_DO) count <= ins_count;
      if ((op == emt_pkg::OP_TRIM_RUN) && !in_tab) count <= kc;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      emt_pkg::OP_LOAD: begin
        lb        <= in_data[31:0];
        pb        <= in_data[63:32];
        len       <= in_data[78:64];
        keep      <= in_data[110:79];
        idx       <= '0;
        kc        <= '0;
        any_freed <= 1'b0;
        have_l    <= 1'b0;
      end
      emt_pkg::OP_INS_SCAN: begin
        if (!dp_st.scan_done) begin
          l_ls   <= c_ls;
          l_ps   <= c_ps;
          l_len  <= c_len;
          have_l <= 1'b1;
          idx    <= idx + CW'(1);
        end else begin
          r_ls   <= c_ls;
          r_ps   <= c_ps;
          r_len  <= c_len;
          have_r <= in_tab;
        end
      end
      emt_pkg::OP_INS_DO: begin
        o_status <= ins_status;
        o_found  <= 1'b0;
        o_mapped <= '0;
        o_freed  <= '0;
        o_count  <= ins_count;
        out_last <= 1'b1;
      end
      emt_pkg::OP_LOOK: begin
        idx <= idx + CW'(1);
        if (dp_st.look_done) begin
          o_status <= emt_pkg::ST_OK;
          o_found  <= hit;
          o_mapped <= hit ? (c_ps + (lb - c_ls)) : '0;
          o_freed  <= '0;
          o_count  <= count;
          out_last <= 1'b1;
        end
      end
      emt_pkg::OP_TRIM_CNT: begin
        if (in_tab) begin
          if (c_ls < keep) kc <= kc + CW'(1);
          idx <= idx + CW'(1);
        end else begin
          idx <= '0;
        end
      end
      emt_pkg::OP_TRIM_RUN: begin
        if (in_tab) begin
          idx <= idx + CW'(1);
          if (freed) begin
            any_freed <= 1'b1;
            o_status  <= emt_pkg::ST_OK;
            o_found   <= 1'b0;
            o_mapped  <= c_ps + 32'(keep_len);
            o_freed   <= c_len - keep_len;
            o_count   <= kc;
            out_last  <= (idx == count - CW'(1));
          end
        end else if (!any_freed) begin
          o_status <= emt_pkg::ST_OK;
          o_found  <= 1'b0;
          o_mapped <= '0;
          o_freed  <= '0;
          o_count  <= kc;
          out_last <= 1'b1;
        end
      end
      emt_pkg::OP_NULL: begin
        o_status <= emt_pkg::ST_OK;
        o_found  <= 1'b0;
        o_mapped <= '0;
        o_freed  <= '0;
        o_count  <= count;
        out_last <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_data = {1'b0, o_count, o_freed, o_mapped, o_found, o_status};

endmodule

>>> hw/rtl/extent_map_table.sv
// Channel  Direction  Contents
// s_*      in         tuser: command; tdata: logical start, physical start,
//                     run_length_in, keep_count (lowest bits first)
// m_*      out        tdata: status, found, mapped_block, freed_length,
//                     entry_count_out; tlast: last
// cfg_*    in         table_capacity, written when cfg_we is high
//
// One command is in flight at a time; s_tready is high only while idle.
// Insert and lookup scan the extents held at one entry per cycle, the lookup
// scan only while the output register is free; trim makes a counting pass
// then a freeing pass over the entries held.
// rst is synchronous; it empties the table and sets the capacity to 4.
// A result beat waits in the output register; the lookup scan and the freeing
// pass hold on every entry while a previous beat has not been taken.
module extent_map_table #(
  parameter int unsigned MAX_EXTENTS = emt_pkg::MaxExtentsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,   // table_capacity
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,     // logical start, physical start, run_length_in,
                                    // keep_count
  input  logic [1:0]   s_tuser,     // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,     // status, found, mapped_block, freed_length,
                                    // entry_count_out
  output logic         m_tlast
);

  emt_pkg::op_t        op;
  emt_pkg::dp_status_t dp_st;

  // sequence each command: scan, decide, emit beats
  emt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .dp_st    (dp_st),
    .in_ready (s_tready),
    .op       (op)
  );

  // table storage, compare logic and the output register
  emt_dpath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .dp_st     (dp_st),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
